/* rtl/core/packed_sample_unpacker_assert.svh */
// Assertion macros shared by the unpacker RTL.
// Each macro checks on the rising edge of clk and is off while rst is high.
`ifndef PACKED_SAMPLE_UNPACKER_ASSERT_SVH
`define PACKED_SAMPLE_UNPACKER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define PSU_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("unpacker assertion failed");
// Next-cycle implication.
`define PSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("unpacker assertion failed");
`else
`define PSU_ASSERT_IMPLIES(lbl, ante, cons)
`define PSU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/psu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package psu_pkg;

  localparam int WORD_BITS = 16;

  localparam logic [15:0] MIN_PAYLOAD  = 16'd8954;
  localparam logic [7:0]  LAST_COUNTER = 8'd30;
  localparam logic [10:0] APID_A       = 11'd130;
  localparam logic [10:0] APID_B       = 11'd135;
  localparam logic [10:0] APID_C       = 11'd140;

  localparam logic [12:0] SAMPLES_RESET = 13'd1024;
  localparam logic [12:0] SAMPLES_MAX   = 13'd4096;
  localparam logic [4:0]  SEGS_RESET    = 5'd16;

  localparam logic [1:0] CFG_SAMPLES = 2'd0;
  localparam logic [1:0] CFG_SEGS    = 2'd1;
  localparam logic [1:0] CFG_WIDTHS  = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_WORD  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic start;  // apply a start transaction
    logic load;   // capture a payload word
    logic step;   // extract one sample or absorb the rest of the word
  } cmd_t;

  typedef struct packed {
    logic packet_active;
    logic slot_free;
    logic word_done;
  } status_t;

  // Bit width of segment idx, 1..16.
  function automatic logic [4:0] seg_width(input logic [63:0] widths, input logic [3:0] idx);
    logic [63:0] sh;
    sh = widths >> {idx, 2'b00};
    return {1'b0, sh[3:0]} + 5'd1;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/psu_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module psu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            command,
  input  psu_pkg::status_t status,
  output psu_pkg::cmd_t   cmd
);
  import psu_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == CMD_START) begin
            cmd.start = 1'b1;
          end else if (status.packet_active) begin
            cmd.load   = 1'b1;
            state_next = ST_RUN;
          end
          // drop words that arrive with no packet active
        end
      end
      ST_RUN: begin
        if (status.slot_free) begin
          cmd.step = 1'b1;
          if (status.word_done) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/psu_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module psu_dp #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_CHANNELS = 16384
) (
  input  logic             clk,
  input  logic             rst,
  input  psu_pkg::cmd_t    cmd,
  output psu_pkg::status_t status,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  input  logic [10:0]      apid,
  input  logic [7:0]       counter,
  input  logic [15:0]      payload_bytes,
  input  logic [15:0]      data_word,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      sample_value,
  output logic [13:0]      channel,
  output logic [15:0]      row,
  output logic [5:0]       column,
  output logic             last
);
  import psu_pkg::*;

  // configuration
  logic [12:0] samples_cfg;
  logic [4:0]  segs_cfg;
  logic [63:0] widths_cfg;

  // packet and unpacking state
  logic [15:0] line_count;
  logic [15:0] row_latch;
  logic [5:0]  column_latch;
  logic        packet_active;
  logic [3:0]  segment_index;
  logic [11:0] sample_index;
  logic [13:0] channel_index;
  logic [15:0] partial_sample;
  logic [4:0]  bits_gathered;
  logic [15:0] word;
  logic [4:0]  bit_pos;

  // step logic
  logic [12:0] eff_samples;
  logic [4:0]  eff_segs;
  logic [4:0]  width_cur;
  logic [4:0]  need;
  logic [4:0]  remain;
  logic        emit;
  logic [15:0] shifted;
  logic [16:0] mask_wide;
  logic [15:0] bits;
  logic [31:0] contrib_wide;
  logic [15:0] contrib;
  logic [4:0]  pos_after;
  logic        sample_wrap;
  logic        seg_wrap;
  logic [3:0]  seg_after;
  logic [5:0]  pos_plus_next;
  logic        step_last;
  logic [14:0] chan_inc;
  logic [13:0] chan_after;

  // start decode
  logic        long_enough;
  logic        counter_ok;
  logic        roff;
  logic        coff;
  logic [7:0]  counter_m1;

  always_comb begin
    if (samples_cfg == 13'd0) begin
      eff_samples = 13'd1;
    end else if (samples_cfg > SAMPLES_MAX) begin
      eff_samples = SAMPLES_MAX;
    end else begin
      eff_samples = samples_cfg;
    end
    if (segs_cfg == 5'd0) begin
      eff_segs = 5'd1;
    end else if (segs_cfg > 5'(MAX_SEGMENTS)) begin
      eff_segs = 5'(MAX_SEGMENTS);
    end else begin
      eff_segs = segs_cfg;
    end
  end

  always_comb begin
    width_cur    = seg_width(widths_cfg, segment_index);
    need         = (bits_gathered >= width_cur) ? 5'd1 : (width_cur - bits_gathered);
    remain       = 5'(WORD_BITS) - bit_pos;
    emit         = (need <= remain);
    shifted      = word >> bit_pos;
    mask_wide    = (17'd1 << need) - 17'd1;
    bits         = emit ? (shifted & mask_wide[15:0]) : shifted;
    contrib_wide = {16'b0, bits} << bits_gathered;
    contrib      = contrib_wide[15:0];
    pos_after    = bit_pos + need;
    sample_wrap  = ({1'b0, sample_index} + 13'd1) >= eff_samples;
    seg_wrap     = sample_wrap && (({1'b0, segment_index} + 5'd1) >= eff_segs);
    seg_after    = sample_wrap ? (segment_index + 4'd1) : segment_index;
    pos_plus_next = {1'b0, pos_after} + {1'b0, seg_width(widths_cfg, seg_after)};
    // no further sample can finish inside this word
    step_last    = seg_wrap || (pos_plus_next > 6'(WORD_BITS));
    chan_inc     = {1'b0, channel_index} + 15'd1;
    chan_after   = (chan_inc >= 15'(MAX_CHANNELS)) ? 14'd0 : chan_inc[13:0];
  end

  always_comb begin
    long_enough = (payload_bytes >= MIN_PAYLOAD);
    counter_ok  = (counter != 8'd0) && (counter <= LAST_COUNTER);
    roff        = (apid == APID_A) || (apid == APID_C);
    coff        = (apid == APID_A) || (apid == APID_B);
    counter_m1  = counter - 8'd1;
  end

  assign status.packet_active = packet_active;
  assign status.slot_free     = !out_valid || out_ready;
  // trailing bits after the last sample of a word still need an absorb step
  assign status.word_done     = !emit || seg_wrap || (pos_after == 5'(WORD_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_cfg <= SAMPLES_RESET;
      segs_cfg    <= SEGS_RESET;
      widths_cfg  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLES: samples_cfg <= cfg_data[12:0];
        CFG_SEGS:    segs_cfg    <= cfg_data[4:0];
        CFG_WIDTHS:  widths_cfg  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count     <= '0;
      row_latch      <= '0;
      column_latch   <= '0;
      packet_active  <= 1'b0;
      segment_index  <= '0;
      sample_index   <= '0;
      channel_index  <= '0;
      partial_sample <= '0;
      bits_gathered  <= '0;
      bit_pos        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.start) begin
        segment_index  <= '0;
        sample_index   <= '0;
        channel_index  <= '0;
        partial_sample <= '0;
        bits_gathered  <= '0;
        packet_active  <= long_enough && counter_ok;
        if (long_enough && counter_ok) begin
          row_latch    <= line_count + {15'b0, roff};
          column_latch <= {counter_m1[4:0], 1'b0} + {5'b0, coff};
        end
        if (long_enough && (counter == LAST_COUNTER) && (apid == APID_A)) begin
          line_count <= line_count + 16'd2;
        end
      end
      if (cmd.load) begin
        bit_pos <= '0;
      end
      if (cmd.step) begin
        if (emit) begin
          partial_sample <= '0;
          bits_gathered  <= '0;
          bit_pos        <= pos_after;
          channel_index  <= chan_after;
          sample_index   <= sample_wrap ? 12'd0 : (sample_index + 12'd1);
          segment_index  <= seg_wrap ? 4'd0 : seg_after;
          if (seg_wrap) begin
            packet_active <= 1'b0;
          end
        end else begin
          partial_sample <= partial_sample | contrib;
          bits_gathered  <= bits_gathered + remain;
          bit_pos        <= 5'(WORD_BITS);
        end
      end
      if (cmd.step && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= data_word;
    end
    if (cmd.step && emit) begin
      sample_value <= partial_sample | contrib;
      channel      <= channel_index;
      row          <= row_latch;
      column       <= column_latch;
      last         <= step_last;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/packed_sample_unpacker.sv */
// A start transaction is taken while idle; a payload word is loaded while idle, then the
//   extractor steps once per finished sample, each sample showing on the output the cycle after its step.
// A further absorb step takes in trailing bits that finish no sample while the packet stays open;
//   no new transaction is taken until the word is done; a full output register stalls each step.
// Reset: rst is synchronous, active high; clears config to 1024 / 16 / 0 and all packet state.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_sample_unpacker_assert.svh"
module packed_sample_unpacker #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_CHANNELS = 16384
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [10:0] apid,
  input  logic [7:0]  counter,
  input  logic [15:0] payload_bytes,
  input  logic [15:0] data_word,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] sample_value,
  output logic [13:0] channel,
  output logic [15:0] row,
  output logic [5:0]  column,
  output logic        last
);
  import psu_pkg::*;

  // The controller decides what happens each cycle: take a start or word
  // transaction while idle, then step the extractor once per cycle while the
  // output register has room. The datapath holds the packet state, the word
  // under extraction and the output register, so a finished sample can wait
  // for the consumer while the next transaction is already taken.
  cmd_t    ctrl_cmd;
  status_t dp_status;

  psu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  psu_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctrl_cmd),
    .status        (dp_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .apid          (apid),
    .counter       (counter),
    .payload_bytes (payload_bytes),
    .data_word     (data_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_value  (sample_value),
    .channel       (channel),
    .row           (row),
    .column        (column),
    .last          (last)
  );

  // Never step the extractor into a full output register.
  `PSU_ASSERT_IMPLIES(a_step_needs_slot, ctrl_cmd.step, out_ready || !out_valid)
  // Extraction and intake never overlap.
  `PSU_ASSERT_IMPLIES(a_step_not_ready, ctrl_cmd.step, !in_ready)
  // A word is only loaded for an active packet.
  `PSU_ASSERT_IMPLIES(a_load_active, ctrl_cmd.load, dp_status.packet_active)
  // Once a word finishes, intake opens again.
  `PSU_ASSERT_NEXT(a_done_reopens, ctrl_cmd.step && dp_status.word_done, in_ready)

endmodule
`default_nettype wire

/* tb/sample_stream_checker.sv */
`timescale 1ns / 1ps
module sample_stream_checker #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_CHANNELS = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [10:0] apid,
  input  logic [7:0]  counter,
  input  logic [15:0] payload_bytes,
  input  logic [15:0] data_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] sample_value,
  input  logic [13:0] channel,
  input  logic [15:0] row,
  input  logic [5:0]  column,
  input  logic        last,
  output int          mismatches,
  output int          outstanding
);
  import psu_pkg::*;

  typedef struct packed {
    logic [15:0] value;
    logic [13:0] chan;
    logic [15:0] row;
    logic [5:0]  col;
    logic        last;
  } sample_t;

  // Shadow of the configuration registers.
  logic [12:0] samples_reg;
  logic [4:0]  segs_reg;
  logic [63:0] widths_reg;

  // Shadow of the unpacking state.
  logic [15:0] lines;
  logic [15:0] row_hold;
  logic [5:0]  col_hold;
  logic        in_packet;
  int          seg_idx;
  int          sample_idx;
  int          chan_idx;
  logic [15:0] acc;
  int          acc_bits;

  sample_t expected_samples[$];
  sample_t front;

  initial mismatches = 0;
  initial outstanding = 0;

  task automatic open_packet(input logic [10:0] ap, input logic [7:0] cnt,
                             input logic [15:0] bytes);
    logic [15:0] roff;
    logic [5:0]  coff;
    roff = '0;
    coff = '0;
    seg_idx = 0;
    sample_idx = 0;
    chan_idx = 0;
    acc = '0;
    acc_bits = 0;
    in_packet = 1'b0;
    if (bytes >= MIN_PAYLOAD) begin
      if (ap == APID_A) begin
        roff = 16'd1;
        coff = 6'd1;
      end else if (ap == APID_B) begin
        coff = 6'd1;
      end else if (ap == APID_C) begin
        roff = 16'd1;
      end
      if (cnt >= 8'd1 && cnt <= LAST_COUNTER) begin
        in_packet = 1'b1;
        row_hold = lines + roff;
        col_hold = 6'(2 * (int'(cnt) - 1) + int'(coff));
      end
      // frame marker: bump the line count after this packet's row is latched
      if (cnt == LAST_COUNTER && ap == APID_A) lines = lines + 16'd2;
    end
  endtask

  task automatic unpack_word(input logic [15:0] word);
    sample_t held;
    bit      have_held;
    int      width;
    int      per_seg;
    int      seg_total;
    held = '0;
    have_held = 1'b0;
    per_seg = (samples_reg == 13'd0) ? 1 :
              (samples_reg > SAMPLES_MAX) ? int'(SAMPLES_MAX) : int'(samples_reg);
    seg_total = (segs_reg == 5'd0) ? 1 :
                (int'(segs_reg) > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(segs_reg);
    for (int b = 0; b < 16 && in_packet; b++) begin
      if (acc_bits < 16) acc[acc_bits] = word[b];
      acc_bits++;
      width = int'((widths_reg >> (4 * seg_idx)) & 64'hF) + 1;
      if (acc_bits >= width) begin
        // hold the newest sample back so the final one of the word gets its last flag
        if (have_held) expected_samples.push_back(held);
        held.value = acc;
        held.chan = 14'(chan_idx);
        held.row = row_hold;
        held.col = col_hold;
        held.last = 1'b0;
        have_held = 1'b1;
        acc = '0;
        acc_bits = 0;
        chan_idx = (chan_idx + 1 >= MAX_CHANNELS) ? 0 : chan_idx + 1;
        sample_idx++;
        if (sample_idx >= per_seg) begin
          sample_idx = 0;
          seg_idx++;
          if (seg_idx >= seg_total) begin
            seg_idx = 0;
            in_packet = 1'b0;
          end
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_samples.push_back(held);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      samples_reg = SAMPLES_RESET;
      segs_reg = SEGS_RESET;
      widths_reg = '0;
      lines = '0;
      row_hold = '0;
      col_hold = '0;
      in_packet = 1'b0;
      seg_idx = 0;
      sample_idx = 0;
      chan_idx = 0;
      acc = '0;
      acc_bits = 0;
      expected_samples.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample: value %0h, channel %0d", sample_value, channel);
          mismatches++;
        end else begin
          front = expected_samples.pop_front();
          check_field("sample_value", front.value, sample_value);
          check_field("channel", 16'(front.chan), 16'(channel));
          check_field("row", front.row, row);
          check_field("column", 16'(front.col), 16'(column));
          check_field("last", 16'(front.last), 16'(last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLES: samples_reg = cfg_data[12:0];
          CFG_SEGS:    segs_reg = cfg_data[4:0];
          CFG_WIDTHS:  widths_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (command == CMD_START) open_packet(apid, counter, payload_bytes);
        else unpack_word(data_word);
      end
    end
    outstanding <= expected_samples.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import psu_pkg::*;

  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Extra cycles after the last result, covering a word that finishes no sample.
  localparam int SETTLE_CYCLES = 4;
  localparam int TRAFFIC_ITEMS = 140;
  // Apid with no offsets, used as a plain science packet.
  localparam logic [10:0] APID_PLAIN = 11'd145;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SAMPLES;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_START;
  logic [10:0] apid = '0;
  logic [7:0]  counter = '0;
  logic [15:0] payload_bytes = '0;
  logic [15:0] data_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] sample_value;
  logic [13:0] channel;
  logic [15:0] row;
  logic [5:0]  column;
  logic        last;

  int mismatches;
  int outstanding;
  int stall_cycles = 0;
  // Percent of cycles in which each side holds back.
  int tx_idle_pct = 19;
  int rx_idle_pct = 85;

  always #5 clk = ~clk;

  packed_sample_unpacker dut (.*);

  sample_stream_checker checker_i (.*);

  // Receiver: drop ready at random at the current idle rate.
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

  // Watchdog: count cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Present one input transaction and hold it until accepted. Valid stays high
  // afterwards so back-to-back transactions need no extra edge; a gap lowers it.
  task automatic offer_item(input logic cmd, input logic [10:0] ap, input logic [7:0] cnt,
                            input logic [15:0] bytes, input logic [15:0] word);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    apid <= ap;
    counter <= cnt;
    payload_bytes <= bytes;
    data_word <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  // Unused fields still carry random values so every bit toggles.
  task automatic send_start(input logic [10:0] ap, input logic [7:0] cnt,
                            input logic [15:0] bytes);
    offer_item(CMD_START, ap, cnt, bytes, 16'($urandom));
  endtask

  task automatic send_word(input logic [15:0] word);
    offer_item(CMD_WORD, 11'($urandom), 8'($urandom), 16'($urandom), word);
  endtask

  // Drop valid and wait until every predicted sample has come out and the
  // block has had time to finish a word that produced nothing.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Upper bits beyond each register's width are junk and must be ignored.
  task automatic configure(input logic [12:0] n_samples, input logic [4:0] n_segs,
                           input logic [63:0] widths);
    write_reg(CFG_SAMPLES, {51'({$urandom, $urandom}), n_samples});
    write_reg(CFG_SEGS, {59'({$urandom, $urandom}), n_segs});
    write_reg(CFG_WIDTHS, widths);
  endtask

  // Mostly short packets so they finish often; now and then a clamped extreme.
  task automatic pick_config();
    logic [12:0] n_samples;
    logic [4:0]  n_segs;
    logic [63:0] widths;
    case ($urandom_range(0, 9))
      0: n_samples = 13'd0;
      1: n_samples = 13'($urandom_range(4097, 8191));
      default: n_samples = 13'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0: n_segs = 5'd0;
      1: n_segs = 5'($urandom_range(16, 31));
      default: n_segs = 5'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 7))
      0: widths = '0;
      1: widths = '1;
      default: widths = {$urandom, $urandom};
    endcase
    configure(n_samples, n_segs, widths);
  endtask

  function automatic logic [10:0] pick_apid();
    case ($urandom_range(0, 5))
      0: return APID_A;
      1: return APID_B;
      2: return APID_C;
      3: return APID_PLAIN;
      default: return 11'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random traffic: mostly accepted packets with a few payload words, the
  // rest rejected headers, fully random headers and stray words.
  task automatic run_traffic(input int items);
    int sent;
    int words;
    sent = 0;
    while (sent < items) begin
      // occasionally retune the registers, possibly in the middle of a packet
      if ($urandom_range(0, 29) == 0) pick_config();
      case ($urandom_range(0, 9))
        0: send_start(pick_apid(), 8'($urandom), 16'($urandom_range(0, 8953)));
        1: send_start(pick_apid(),
                      $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(31, 255)),
                      16'($urandom_range(8954, 65535)));
        2: send_start(11'($urandom), 8'($urandom), 16'($urandom));
        3: send_word(pick_word());
        default: begin
          send_start(pick_apid(), 8'($urandom_range(1, 30)),
                     16'($urandom_range(8954, 65535)));
          words = $urandom_range(1, 6);
          repeat (words) send_word(pick_word());
          sent += words;
        end
      endcase
      sent++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset registers give 1-bit samples, 1024 per segment.
    send_word(16'hFFFF);                       // no packet open: drop
    send_start(11'h7FF, 8'd5, 16'd8953);       // payload one byte short
    send_word(16'h1234);
    send_start(11'd0, 8'd0, 16'hFFFF);         // counter zero
    send_start(APID_PLAIN, 8'd31, 16'd9000);   // counter past the last column
    send_start(APID_A, 8'hFF, 16'hFFFF);
    send_start(APID_A, 8'd1, MIN_PAYLOAD);     // both offsets, first column
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'hA5C3);
    send_start(APID_B, LAST_COUNTER, 16'hFFFF); // column offset only, last column
    send_word(16'h8001);
    send_start(APID_A, LAST_COUNTER, MIN_PAYLOAD); // frame marker advances the lines
    send_word(16'h7FFE);
    send_start(APID_C, 8'd1, 16'd60000);       // row offset only
    send_word(16'hFFFF);

    // Mixed widths 16 / 1 / 8, two samples each; the packet ends inside a word.
    configure(13'd2, 5'd3, 64'h70F);
    send_start(APID_PLAIN, 8'd17, MIN_PAYLOAD);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h1234);
    // Narrow the open 8-bit sample to 1 bit: it flushes at the next bit.
    write_reg(CFG_WIDTHS, 64'h0);
    send_word(16'hFFFF);
    send_word(16'hBEEF);                       // packet already closed

    // Sender light, receiver heavy; one 16-bit sample per segment.
    configure(13'd0, SEGS_RESET, '1);
    run_traffic(TRAFFIC_ITEMS);

    // Sender heavy, receiver light; zero segment count.
    drain();
    tx_idle_pct = 85;
    rx_idle_pct = 19;
    configure(13'd3, 5'd0, {$urandom, $urandom});
    run_traffic(TRAFFIC_ITEMS);

    // Full rate from here on.
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pick_config();
    run_traffic(TRAFFIC_ITEMS);

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* packed_sample_unpacker.f */
+incdir+rtl/core
rtl/core/psu_pkg.sv
rtl/core/psu_ctrl.sv
rtl/core/psu_dp.sv
rtl/core/packed_sample_unpacker.sv
tb/sample_stream_checker.sv
tb/tb.sv
